@@ sv/idle_power_mode_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Idle power mode controller assertion macros
// Shared concurrent assertion forms; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef IDLE_POWER_MODE_CONTROLLER_ASSERT_SVH
`define IDLE_POWER_MODE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define IPMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipmc: same-cycle check failed");

// Next-cycle implication.
`define IPMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipmc: next-cycle check failed");

`else

`define IPMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IPMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/ipmc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipmc_pkg
// Types, constants and register map of the idle power mode controller.
// ----------------------------------------------------------------------------
package ipmc_pkg;

  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IMG_W     = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned STEP_W    = 6;

  // Upper limit on the number of screensaver images in rotation.
  localparam int unsigned MAX_IMAGES = 255;

  localparam logic [CFG_W-1:0] DIM_AFTER_RST     = 32'd60000;
  localparam logic [CFG_W-1:0] SAVER_AFTER_RST   = 32'd120000;
  localparam logic [CFG_W-1:0] OFF_AFTER_RST     = 32'd300000;
  localparam logic [CFG_W-1:0] ROTATE_PERIOD_RST = 32'd30000;
  localparam logic [CFG_W-1:0] URGENT_WINDOW_RST = 32'd8000;
  localparam logic [IMG_W-1:0] IMAGE_COUNT_RST   = 8'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL,
    MODE_DIM,
    MODE_SAVER,
    MODE_OFF
  } mode_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_UPDATE,
    FN_TOUCH,
    FN_URGENT,
    FN_RESTART
  } func_t;

  typedef enum logic [2:0] {
    REG_DIM_AFTER,
    REG_SAVER_AFTER,
    REG_OFF_AFTER,
    REG_ROTATE_PERIOD,
    REG_URGENT_WINDOW,
    REG_IMAGE_COUNT
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] dim_after;
    logic [CFG_W-1:0] saver_after;
    logic [CFG_W-1:0] off_after;
    logic [CFG_W-1:0] rotate_period;
    logic [CFG_W-1:0] urgent_window;
    logic [IMG_W-1:0] image_count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic decide;
    logic div_step;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

@@ sv/ipmc_regs.sv @@
// ----------------------------------------------------------------------------
// ipmc_regs
// APB register file holding the thresholds, urgent window, rotation period and image count.
// ----------------------------------------------------------------------------
module ipmc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ipmc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ipmc_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [ipmc_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output ipmc_pkg::cfg_t               cfg
);
  import ipmc_pkg::*;

  logic [CFG_W-1:0] dim_after_r, dim_after_nxt;
  logic [CFG_W-1:0] saver_after_r, saver_after_nxt;
  logic [CFG_W-1:0] off_after_r, off_after_nxt;
  logic [CFG_W-1:0] rotate_period_r, rotate_period_nxt;
  logic [CFG_W-1:0] urgent_window_r, urgent_window_nxt;
  logic [IMG_W-1:0] image_count_r, image_count_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_comb begin
    dim_after_nxt     = dim_after_r;
    saver_after_nxt   = saver_after_r;
    off_after_nxt     = off_after_r;
    rotate_period_nxt = rotate_period_r;
    urgent_window_nxt = urgent_window_r;
    image_count_nxt   = image_count_r;
    if (wr_en) begin
      case (idx)
        REG_DIM_AFTER:     dim_after_nxt     = cfg_pwdata;
        REG_SAVER_AFTER:   saver_after_nxt   = cfg_pwdata;
        REG_OFF_AFTER:     off_after_nxt     = cfg_pwdata;
        REG_ROTATE_PERIOD: rotate_period_nxt = cfg_pwdata;
        REG_URGENT_WINDOW: urgent_window_nxt = cfg_pwdata;
        REG_IMAGE_COUNT:   image_count_nxt   = cfg_pwdata[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIM_AFTER:     cfg_prdata = dim_after_r;
      REG_SAVER_AFTER:   cfg_prdata = saver_after_r;
      REG_OFF_AFTER:     cfg_prdata = off_after_r;
      REG_ROTATE_PERIOD: cfg_prdata = rotate_period_r;
      REG_URGENT_WINDOW: cfg_prdata = urgent_window_r;
      REG_IMAGE_COUNT:   cfg_prdata = {{(CFG_W-IMG_W){1'b0}}, image_count_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_r     <= DIM_AFTER_RST;
      saver_after_r   <= SAVER_AFTER_RST;
      off_after_r     <= OFF_AFTER_RST;
      rotate_period_r <= ROTATE_PERIOD_RST;
      urgent_window_r <= URGENT_WINDOW_RST;
      image_count_r   <= IMAGE_COUNT_RST;
    end else begin
      dim_after_r     <= dim_after_nxt;
      saver_after_r   <= saver_after_nxt;
      off_after_r     <= off_after_nxt;
      rotate_period_r <= rotate_period_nxt;
      urgent_window_r <= urgent_window_nxt;
      image_count_r   <= image_count_nxt;
    end
  end

  assign cfg.dim_after     = dim_after_r;
  assign cfg.saver_after   = saver_after_r;
  assign cfg.off_after     = off_after_r;
  assign cfg.rotate_period = rotate_period_r;
  assign cfg.urgent_window = urgent_window_r;
  assign cfg.image_count   = image_count_r;

endmodule

@@ sv/ipmc_dp.sv @@
// ----------------------------------------------------------------------------
// ipmc_dp
// Timer state, mode selection, bit-serial rotation divider and result register.
// ----------------------------------------------------------------------------
`include "idle_power_mode_controller_assert.svh"

module ipmc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ipmc_pkg::cmd_t                    cmd,
  output ipmc_pkg::sts_t                    sts,
  input  ipmc_pkg::cfg_t                    cfg,
  input  logic [ipmc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [ipmc_pkg::FUNC_W-1:0]       in_tuser,
  output logic [ipmc_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ipmc_pkg::*;

  // Captured transaction and precomputed differences.
  func_t             func_r, func_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              talk_r, talk_nxt;
  logic [TIME_W-1:0] idle_r, idle_nxt;
  logic [TIME_W-1:0] elap_r, elap_nxt;
  logic              urg_r, urg_nxt;

  // Controller state.
  logic [TIME_W-1:0] last_touch_r, last_touch_nxt;
  logic [TIME_W-1:0] urgent_end_r, urgent_end_nxt;
  logic [TIME_W-1:0] last_rot_r, last_rot_nxt;
  mode_t             mode_r, mode_nxt;
  logic [IMG_W-1:0]  image_r, image_nxt;

  // Divider.
  logic [TIME_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  per_r, per_nxt;
  logic [IMG_W-1:0]  cnt_r, cnt_nxt;
  logic [IMG_W-1:0]  amod_r, amod_nxt;
  logic [IMG_W-1:0]  qmod_r, qmod_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Result register.
  mode_t             out_mode_r, out_mode_nxt;
  logic [IMG_W-1:0]  out_image_r, out_image_nxt;

  logic [IMG_W-1:0]  cnt_eff;
  logic [CFG_W-1:0]  per_eff;
  logic              touch_ev;
  logic              tick_ev;
  mode_t             mode_sel;
  logic              need_div;
  logic [CFG_W:0]    rem_sh;
  logic              q_bit;
  logic [CFG_W-1:0]  rem_step;
  logic [IMG_W:0]    q_sh;
  logic [IMG_W-1:0]  qmod_step;
  logic              a_bit;
  logic [IMG_W:0]    a_sh;
  logic [IMG_W-1:0]  amod_step;
  logic [IMG_W:0]    idx_sum;
  logic [IMG_W-1:0]  idx_fin;

  assign cnt_eff = (32'(cfg.image_count) > 32'(MAX_IMAGES)) ? IMG_W'(MAX_IMAGES)
                                                           : cfg.image_count;
  assign per_eff = (cfg.rotate_period == '0) ? CFG_W'(1) : cfg.rotate_period;

  assign touch_ev = (func_r == FN_TOUCH) || ((func_r == FN_UPDATE) && talk_r);
  assign tick_ev  = (func_r == FN_UPDATE) && !talk_r;

  always_comb begin
    if (urg_r) begin
      mode_sel = MODE_NORMAL;
    end else if (idle_r >= {{(TIME_W-CFG_W){1'b0}}, cfg.off_after}) begin
      mode_sel = MODE_OFF;
    end else if (idle_r >= {{(TIME_W-CFG_W){1'b0}}, cfg.saver_after}) begin
      mode_sel = MODE_SAVER;
    end else if (idle_r >= {{(TIME_W-CFG_W){1'b0}}, cfg.dim_after}) begin
      mode_sel = MODE_DIM;
    end else begin
      mode_sel = MODE_NORMAL;
    end
  end

  assign need_div = tick_ev && (mode_sel == MODE_SAVER) && (mode_r == MODE_SAVER) &&
                    (cnt_eff != '0) &&
                    (elap_r >= {{(TIME_W-CFG_W){1'b0}}, per_eff});

  // One restoring-division step per cycle. The quotient is never kept whole:
  // each new quotient bit is folded into its residue modulo the image count.
  assign rem_sh    = {rem_r, dvd_r[TIME_W-1]};
  assign q_bit     = rem_sh >= {1'b0, per_r};
  assign rem_step  = q_bit ? CFG_W'(rem_sh - {1'b0, per_r}) : rem_sh[CFG_W-1:0];
  assign q_sh      = {qmod_r, q_bit};
  assign qmod_step = (q_sh >= {1'b0, cnt_r}) ? IMG_W'(q_sh - {1'b0, cnt_r})
                                             : q_sh[IMG_W-1:0];

  // The current index is reduced the same way during the first steps and
  // then held.
  assign a_bit     = (step_r < STEP_W'(IMG_W)) ?
                     image_r[3'(IMG_W-1) - step_r[2:0]] : 1'b0;
  assign a_sh      = {amod_r, a_bit};
  assign amod_step = (a_sh >= {1'b0, cnt_r}) ? IMG_W'(a_sh - {1'b0, cnt_r})
                                             : a_sh[IMG_W-1:0];

  assign idx_sum = {1'b0, amod_r} + {1'b0, qmod_r};
  assign idx_fin = (idx_sum >= {1'b0, cnt_r}) ? IMG_W'(idx_sum - {1'b0, cnt_r})
                                              : idx_sum[IMG_W-1:0];

  assign sts.need_div = need_div;
  assign sts.div_last = (step_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    func_nxt       = func_r;
    now_nxt        = now_r;
    talk_nxt       = talk_r;
    idle_nxt       = idle_r;
    elap_nxt       = elap_r;
    urg_nxt        = urg_r;
    last_touch_nxt = last_touch_r;
    urgent_end_nxt = urgent_end_r;
    last_rot_nxt   = last_rot_r;
    mode_nxt       = mode_r;
    image_nxt      = image_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    per_nxt        = per_r;
    cnt_nxt        = cnt_r;
    amod_nxt       = amod_r;
    qmod_nxt       = qmod_r;
    step_nxt       = step_r;
    out_mode_nxt   = out_mode_r;
    out_image_nxt  = out_image_r;

    if (cmd.load) begin
      func_nxt = func_t'(in_tuser);
      now_nxt  = in_tdata[TIME_W-1:0];
      talk_nxt = in_tdata[TIME_W];
    end

    if (cmd.calc) begin
      idle_nxt = now_r - last_touch_r;
      elap_nxt = now_r - last_rot_r;
      urg_nxt  = now_r < urgent_end_r;
    end

    if (cmd.decide) begin
      if (touch_ev) begin
        last_touch_nxt = now_r;
        mode_nxt       = MODE_NORMAL;
        image_nxt      = '0;
      end else if (func_r == FN_URGENT) begin
        urgent_end_nxt = now_r + {{(TIME_W-CFG_W){1'b0}}, cfg.urgent_window};
      end else if (func_r == FN_RESTART) begin
        last_touch_nxt = now_r;
        last_rot_nxt   = now_r;
        urgent_end_nxt = '0;
        mode_nxt       = MODE_NORMAL;
        image_nxt      = '0;
      end else begin
        mode_nxt = mode_sel;
        if ((mode_sel == MODE_SAVER) && (mode_r != MODE_SAVER)) begin
          last_rot_nxt = now_r;
          image_nxt    = '0;
        end
      end
      dvd_nxt  = elap_r;
      rem_nxt  = '0;
      per_nxt  = per_eff;
      cnt_nxt  = cnt_eff;
      amod_nxt = '0;
      qmod_nxt = '0;
      step_nxt = '0;
    end

    if (cmd.div_step) begin
      dvd_nxt  = {dvd_r[TIME_W-2:0], 1'b0};
      rem_nxt  = rem_step;
      qmod_nxt = qmod_step;
      if (step_r < STEP_W'(IMG_W)) begin
        amod_nxt = amod_step;
      end
      step_nxt = step_r + STEP_W'(1);
    end

    // Whole periods times the period equals elapsed time minus the remainder.
    if (cmd.fin) begin
      image_nxt    = idx_fin;
      last_rot_nxt = now_r - {{(TIME_W-CFG_W){1'b0}}, rem_r};
    end

    if (cmd.out_load) begin
      out_mode_nxt  = mode_r;
      out_image_nxt = image_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_touch_r <= '0;
      urgent_end_r <= '0;
      last_rot_r   <= '0;
      mode_r       <= MODE_NORMAL;
      image_r      <= '0;
      step_r       <= '0;
    end else begin
      last_touch_r <= last_touch_nxt;
      urgent_end_r <= urgent_end_nxt;
      last_rot_r   <= last_rot_nxt;
      mode_r       <= mode_nxt;
      image_r      <= image_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    now_r       <= now_nxt;
    talk_r      <= talk_nxt;
    idle_r      <= idle_nxt;
    elap_r      <= elap_nxt;
    urg_r       <= urg_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    per_r       <= per_nxt;
    cnt_r       <= cnt_nxt;
    amod_r      <= amod_nxt;
    qmod_r      <= qmod_nxt;
    out_mode_r  <= out_mode_nxt;
    out_image_r <= out_image_nxt;
  end

  assign out_tdata = {{(OUT_DATA_W-IMG_W-MODE_W){1'b0}}, out_image_r, out_mode_r};

  `IPMC_ASSERT_NXT(a_index_below_count, clk, rst_n, cmd.fin, image_r < cnt_r)

endmodule

@@ sv/ipmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ipmc_ctrl
// Sequencer for one event transaction and owner of the result valid flag.
// ----------------------------------------------------------------------------
`include "idle_power_mode_controller_assert.svh"

module ipmc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ipmc_pkg::sts_t  sts,
  output ipmc_pkg::cmd_t  cmd
);
  import ipmc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold here while the previous result is still waiting downstream.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `IPMC_ASSERT_NXT(a_div_holds, clk, rst_n, state_r == S_DIV && !sts.div_last, state_r == S_DIV)
  `IPMC_ASSERT_NXT(a_div_ends, clk, rst_n, state_r == S_DIV && sts.div_last, state_r == S_FIN)
  `IPMC_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_tready)

endmodule

@@ sv/idle_power_mode_controller.sv @@
// Each event transaction passes through load, calc and decide steps, and out_tvalid
// rises once the result is loaded into the output register; an index advance adds
// 64 restoring-divider steps, one quotient bit a cycle, and one finishing step.
// The next event is taken only once the result sits in the output register, so
// events never overlap; acceptance waits longer while out_tready stays low.
// Synchronous active-low reset clears timers, mode, index; loads register defaults.
// ----------------------------------------------------------------------------
// idle_power_mode_controller
// Picks the display mode and screensaver image from timestamped events.
// ----------------------------------------------------------------------------
module idle_power_mode_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] now_ms, [64] talk_active, [71:65] zero
  input  logic [ipmc_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [ipmc_pkg::FUNC_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] mode, [9:2] image_index, [15:10] zero
  output logic [ipmc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ipmc_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [ipmc_pkg::CFG_W-1:0]         cfg_pwdata,
  output logic [ipmc_pkg::CFG_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import ipmc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ipmc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ipmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ipmc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Idle power mode controller testbench
// Sends timestamped events through the input stream, predicts the display mode
// and screensaver image of every event, and checks each result transaction in
// order. It runs a short directed sequence first and then random event
// streams under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipmc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 5'd24;

  typedef struct {
    func_t       fn;
    logic [63:0] now;
    logic        talk;
  } event_t;

  typedef struct {
    mode_t            mode;
    logic [IMG_W-1:0] img;
  } screen_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_W-1:0] cfg_pwdata = '0;
  logic [CFG_W-1:0] cfg_prdata;
  logic cfg_pready;

  idle_power_mode_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pending events, expected screens and bookkeeping.
  event_t  event_q[$];
  screen_t screen_q[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned fails = 0;
  int unsigned quiet = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  logic in_took = 1'b0;
  logic [63:0] clock_ms = '0;

  // Shadow of the registers and of the controller state.
  cfg_t knobs = '{dim_after: DIM_AFTER_RST, saver_after: SAVER_AFTER_RST,
                  off_after: OFF_AFTER_RST, rotate_period: ROTATE_PERIOD_RST,
                  urgent_window: URGENT_WINDOW_RST, image_count: IMAGE_COUNT_RST};
  logic [63:0] touch_ms = '0;
  logic [63:0] urgent_until = '0;
  logic [63:0] rotate_mark = '0;
  mode_t disp_mode = MODE_NORMAL;
  logic [IMG_W-1:0] saver_img = '0;

  function automatic void flag_miss(string what, logic [31:0] want, logic [31:0] got);
    fails++;
    if (fails <= 10)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  function automatic void predict_screen(func_t fn, logic [63:0] t, logic talk);
    mode_t nxt;
    logic [63:0] idle;
    logic [63:0] per;
    logic [63:0] cnt;
    logic [63:0] steps;
    logic [63:0] idx;
    if (fn == FN_TOUCH || (fn == FN_UPDATE && talk)) begin
      touch_ms = t;
      disp_mode = MODE_NORMAL;
      saver_img = '0;
    end else if (fn == FN_UPDATE) begin
      idle = t - touch_ms;
      if (t < urgent_until) nxt = MODE_NORMAL;
      else if (idle >= {32'd0, knobs.off_after}) nxt = MODE_OFF;
      else if (idle >= {32'd0, knobs.saver_after}) nxt = MODE_SAVER;
      else if (idle >= {32'd0, knobs.dim_after}) nxt = MODE_DIM;
      else nxt = MODE_NORMAL;
      if (nxt == MODE_SAVER) begin
        cnt = {56'd0, knobs.image_count};
        per = (knobs.rotate_period == '0) ? 64'd1 : {32'd0, knobs.rotate_period};
        if (cnt > MAX_IMAGES) cnt = MAX_IMAGES;
        if (disp_mode != MODE_SAVER) begin
          rotate_mark = t;
          saver_img = '0;
        end else if (cnt != 0 && t - rotate_mark >= per) begin
          // Whole periods only; the remainder carries into the next update.
          steps = (t - rotate_mark) / per;
          idx = ({56'd0, saver_img} % cnt + steps % cnt) % cnt;
          saver_img = idx[IMG_W-1:0];
          rotate_mark = rotate_mark + steps * per;
        end
      end
      disp_mode = nxt;
    end else if (fn == FN_URGENT) begin
      urgent_until = t + {32'd0, knobs.urgent_window};
    end else begin
      touch_ms = t;
      rotate_mark = t;
      urgent_until = '0;
      disp_mode = MODE_NORMAL;
      saver_img = '0;
    end
    screen_q.push_back('{mode: disp_mode, img: saver_img});
  endfunction

  // Input acceptance, result checking and the activity count for the watchdog.
  always @(posedge clk) begin
    screen_t want;
    in_took <= in_tvalid && in_tready;
    if (out_tvalid && out_tready) begin
      if (screen_q.size() == 0) begin
        flag_miss("unexpected result", '0, {16'd0, out_tdata});
      end else begin
        want = screen_q.pop_front();
        if (out_tdata[1:0] != want.mode || out_tdata[9:2] != want.img) begin
          flag_miss("mode", {30'd0, want.mode}, {30'd0, out_tdata[1:0]});
          if (fails <= 10)
            $display("    image index expected %0d, got %0d", want.img, out_tdata[9:2]);
        end
      end
    end
    if (in_tvalid && in_tready) begin
      predict_screen(func_t'(in_tuser), in_tdata[63:0], in_tdata[64]);
      n_taken++;
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      quiet = 0;
    else
      quiet++;
  end

  always @(negedge clk) begin
    event_t ev;
    if (!in_tvalid || in_took) begin
      if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = event_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= ev.fn;
        in_tdata <= {7'd0, ev.talk, ev.now};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The long hold-off is timed here so the sender keeps offering meanwhile.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    logic [2:0] idx;
    idx = addr[4:2];
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = addr;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      REG_DIM_AFTER: knobs.dim_after = value;
      REG_SAVER_AFTER: knobs.saver_after = value;
      REG_OFF_AFTER: knobs.off_after = value;
      REG_ROTATE_PERIOD: knobs.rotate_period = value;
      REG_URGENT_WINDOW: knobs.urgent_window = value;
      REG_IMAGE_COUNT: knobs.image_count = value[IMG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input reg_idx_t idx, input logic [CFG_W-1:0] want);
    logic [CFG_W-1:0] got;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (got !== want) flag_miss("register read", want, got);
  endtask

  task automatic program_knobs(input cfg_t c);
    apb_write({REG_DIM_AFTER, 2'b00}, c.dim_after);
    apb_write({REG_SAVER_AFTER, 2'b00}, c.saver_after);
    apb_write({REG_OFF_AFTER, 2'b00}, c.off_after);
    apb_write({REG_ROTATE_PERIOD, 2'b00}, c.rotate_period);
    apb_write({REG_URGENT_WINDOW, 2'b00}, c.urgent_window);
    apb_write({REG_IMAGE_COUNT, 2'b00}, {24'd0, c.image_count});
    apb_check(REG_DIM_AFTER, knobs.dim_after);
    apb_check(REG_SAVER_AFTER, knobs.saver_after);
    apb_check(REG_OFF_AFTER, knobs.off_after);
    apb_check(REG_ROTATE_PERIOD, knobs.rotate_period);
    apb_check(REG_URGENT_WINDOW, knobs.urgent_window);
    apb_check(REG_IMAGE_COUNT, {24'd0, knobs.image_count});
  endtask

  task automatic push_event(input func_t fn, input logic [63:0] t, input logic talk);
    event_q.push_back('{fn: fn, now: t, talk: talk});
    n_queued++;
  endtask

  task automatic drain();
    while (n_taken != n_queued || screen_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] lim);
    if (lim == '0) return '0;
    return rand64() % (lim + 64'd1);
  endfunction

  // Mostly a forward-moving clock with ticks; the rest is arbitrary noise.
  function automatic event_t next_event(logic [63:0] step);
    event_t e;
    int unsigned pick;
    int unsigned spread;
    pick = $urandom_range(99);
    spread = $urandom_range(9);
    if (spread == 0) clock_ms = clock_ms + rand_upto(3);
    else if (spread == 1) clock_ms = clock_ms + rand_upto(step * 8);
    else clock_ms = clock_ms + rand_upto(step);
    e.talk = 1'b0;
    if (pick < 70) begin
      e.fn = FN_UPDATE;
      e.talk = $urandom_range(11) == 0;
    end else if (pick < 80) begin
      e.fn = FN_TOUCH;
    end else if (pick < 89) begin
      e.fn = FN_URGENT;
    end else if (pick < 93) begin
      e.fn = FN_RESTART;
    end else begin
      e.fn = func_t'($urandom_range(3));
      e.talk = $urandom_range(1) != 0;
      case ($urandom_range(2))
        0: clock_ms = rand64();
        1: clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - rand_upto(step);
        default: clock_ms = clock_ms - rand_upto(step);
      endcase
    end
    e.now = clock_ms;
    return e;
  endfunction

  task automatic random_phase(input cfg_t c, input logic [63:0] step,
                              input int unsigned s_pct, input int unsigned r_pct,
                              input bit hold);
    event_t e;
    drain();
    program_knobs(c);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      e = next_event(step);
      push_event(e.fn, e.now, e.talk);
    end
    if (hold) hold_req++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 49;

    // Short thresholds so that the dim and saver modes and several rotations are reached.
    program_knobs('{dim_after: 32'd10, saver_after: 32'd20, off_after: 32'd1000,
                    rotate_period: 32'd5, urgent_window: 32'd7, image_count: 8'd4});
    push_event(FN_UPDATE, 64'd0, 1'b0);
    push_event(FN_UPDATE, 64'd0, 1'b1);
    push_event(FN_RESTART, 64'd100, 1'b0);
    push_event(FN_UPDATE, 64'd109, 1'b0);
    push_event(FN_UPDATE, 64'd110, 1'b0);
    push_event(FN_UPDATE, 64'd120, 1'b0);
    push_event(FN_UPDATE, 64'd124, 1'b0);
    push_event(FN_UPDATE, 64'd125, 1'b0);
    push_event(FN_UPDATE, 64'd142, 1'b0);
    push_event(FN_UPDATE, 64'd158, 1'b0);
    push_event(FN_URGENT, 64'd160, 1'b1);
    push_event(FN_UPDATE, 64'd166, 1'b0);
    push_event(FN_UPDATE, 64'd167, 1'b0);
    push_event(FN_UPDATE, 64'd183, 1'b0);
    drain();

    // Fewer images than the current index, a zero period, unmapped addresses.
    apb_write({REG_IMAGE_COUNT, 2'b00}, 32'd2);
    apb_write({REG_ROTATE_PERIOD, 2'b00}, 32'd0);
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_write(UNMAPPED_ADDR + 5'd4, 32'h0000_0001);
    push_event(FN_UPDATE, 64'd185, 1'b0);
    push_event(FN_UPDATE, 64'd1200, 1'b0);
    push_event(FN_TOUCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    push_event(FN_UPDATE, 64'd5, 1'b0);
    push_event(FN_URGENT, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
    push_event(FN_UPDATE, 64'd2, 1'b0);
    push_event(FN_UPDATE, 64'd40, 1'b0);
    push_event(FN_UPDATE, 64'd0, 1'b0);
    push_event(FN_TOUCH, 64'd50, 1'b1);
    push_event(FN_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    clock_ms = 64'hFFFF_FFFF_FFFF_FFFF;

    random_phase('{dim_after: DIM_AFTER_RST, saver_after: SAVER_AFTER_RST,
                   off_after: OFF_AFTER_RST, rotate_period: ROTATE_PERIOD_RST,
                   urgent_window: URGENT_WINDOW_RST, image_count: 8'd6},
                 64'd40000, 19, 49, 1'b0);
    random_phase('{dim_after: 32'd50, saver_after: 32'd100, off_after: 32'd400,
                   rotate_period: 32'd7, urgent_window: 32'd30, image_count: 8'd9},
                 64'd40, 19, 49, 1'b1);
    random_phase('{dim_after: 32'd0, saver_after: 32'd0, off_after: 32'd0,
                   rotate_period: 32'd0, urgent_window: 32'd0, image_count: 8'd0},
                 64'd5, 49, 19, 1'b0);
    random_phase('{dim_after: 32'd30, saver_after: 32'd60, off_after: 32'd5000,
                   rotate_period: 32'd1, urgent_window: 32'd20, image_count: 8'd255},
                 64'd50, 49, 19, 1'b0);
    random_phase('{dim_after: 32'd30, saver_after: 32'd60, off_after: 32'd5000,
                   rotate_period: 32'd3, urgent_window: 32'd20, image_count: 8'd3},
                 64'd50, 0, 0, 1'b0);
    random_phase('{dim_after: 32'hFFFF_FFFF, saver_after: 32'hFFFF_FFFF,
                   off_after: 32'hFFFF_FFFF, rotate_period: 32'hFFFF_FFFF,
                   urgent_window: 32'hFFFF_FFFF, image_count: 8'd200},
                 64'h1_0000_0000, 0, 0, 1'b0);
    random_phase('{dim_after: 32'd1000, saver_after: 32'd2000, off_after: 32'd3000,
                   rotate_period: 32'd100, urgent_window: 32'd500, image_count: 8'd17},
                 64'd1500, 0, 0, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
